[hdl/ffba_pkg.sv]
// Shared types, constants and codes for the first-fit block allocator.
`default_nettype none
package ffba_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int HEADER_BYTES = 16;
	localparam int HEAP_BYTES   = 65536;
	localparam int ADDR_SPACE   = 65536;
	localparam int LIMIT_CAP    = (HEAP_BYTES < ADDR_SPACE) ? HEAP_BYTES : ADDR_SPACE;
	localparam int IDX_W        = $clog2(MAX_BLOCKS);
	localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NULL    = 2'd1;
	localparam logic [1:0] ST_NOSPACE = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	typedef struct packed {
		logic        action;
		logic [15:0] request_size;
		logic [15:0] payload_address;
	} in_t;

	typedef struct packed {
		logic [15:0] result_address;
		logic [1:0]  status;
	} out_t;

	typedef struct packed {
		logic [15:0] start;
		logic [15:0] len;
		logic        free;
	} ent_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       clr_idx;
		logic       rd;
		logic       step;
		logic       hit_wr;
		logic       init_j;
		logic       sh_rd;
		logic       sh_wr;
		logic       split_wr;
		logic       append;
		logic       set_res;
		logic [1:0] res_code;
		logic       out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_free_op;
		logic zero;
		logic scan_end;
		logic hit;
		logic split_ok;
		logic no_shift;
		logic sh_last;
		logic append_ok;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

[hdl/ffba_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

[hdl/ffba_dp.sv]
// Datapath: block table, counters, heap top, limit register and result word.
`default_nettype none
module ffba_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ffba_pkg::cmd_t cmd,
	output ffba_pkg::sts_t     sts,
	input  wire ffba_pkg::in_t in_word,
	input  wire logic          cfg_we,
	input  wire logic [16:0]   cfg_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output ffba_pkg::out_t     out_word
);
	import ffba_pkg::*;

	logic             act_q;
	logic [15:0]      size_q;
	logic [15:0]      addr_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] count_q;
	logic [16:0]      top_q;
	logic [16:0]      limit_q;
	logic [15:0]      hit_start_q;
	logic [15:0]      hit_len_q;
	logic [15:0]      res_addr_q;
	logic [1:0]       res_code_q;
	logic             out_valid_q;
	out_t             out_q;

	ent_t             rdata;
	ent_t             wdata;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic             re;
	logic [IDX_W-1:0] raddr;
	logic [CNT_W-1:0] jm1;
	logic [CNT_W-1:0] idx_p1;
	logic [16:0]      start_p;
	logic [16:0]      need;
	logic [17:0]      end_t;
	logic [16:0]      usable;
	logic [16:0]      top_p;
	logic             room;

	ffba_ram #(.WIDTH($bits(ent_t)), .DEPTH(MAX_BLOCKS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign jm1     = j_q - CNT_W'(1);
	assign idx_p1  = idx_q + CNT_W'(1);
	assign start_p = {1'b0, rdata.start} + 17'(HEADER_BYTES);
	assign need    = {1'b0, size_q} + 17'(HEADER_BYTES);
	assign end_t   = {1'b0, top_q} + {1'b0, need};
	assign top_p   = top_q + 17'(HEADER_BYTES);
	assign usable  = (limit_q > 17'(LIMIT_CAP)) ? 17'(LIMIT_CAP) : limit_q;
	assign room    = count_q < CNT_W'(MAX_BLOCKS);

	assign re    = cmd.rd | cmd.sh_rd;
	assign raddr = cmd.sh_rd ? jm1[IDX_W-1:0] : idx_q[IDX_W-1:0];

	always_comb begin
		we    = 1'b0;
		waddr = idx_q[IDX_W-1:0];
		wdata = rdata;
		if (cmd.hit_wr) begin
			we         = 1'b1;
			wdata.free = (act_q == ACT_FREE);
			if (act_q == ACT_ALLOC && sts.split_ok) begin
				wdata.len = size_q;
			end
		end else if (cmd.sh_wr) begin
			we    = 1'b1;
			waddr = j_q[IDX_W-1:0];
		end else if (cmd.split_wr) begin
			we          = 1'b1;
			waddr       = idx_p1[IDX_W-1:0];
			wdata.start = hit_start_q + 16'(HEADER_BYTES) + size_q;
			wdata.len   = hit_len_q - size_q - 16'(HEADER_BYTES);
			wdata.free  = 1'b1;
		end else if (cmd.append) begin
			we          = 1'b1;
			waddr       = count_q[IDX_W-1:0];
			wdata.start = top_q[15:0];
			wdata.len   = size_q;
			wdata.free  = 1'b0;
		end
	end

	always_comb begin
		sts.is_free_op = (act_q == ACT_FREE);
		sts.zero       = (act_q == ACT_FREE) ? (addr_q == 16'd0) : (size_q == 16'd0);
		sts.scan_end   = (idx_q == count_q);
		sts.hit        = (act_q == ACT_FREE) ? (start_p == {1'b0, addr_q})
		                                     : (rdata.free && rdata.len >= size_q);
		sts.split_ok   = ({1'b0, rdata.len} > need) && room;
		sts.no_shift   = (count_q == idx_p1);
		sts.sh_last    = (jm1 == idx_p1);
		sts.append_ok  = room && (end_t <= {1'b0, usable});
		sts.out_free   = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= in_word.action;
			size_q <= in_word.request_size;
			addr_q <= in_word.payload_address;
		end
		if (cmd.hit_wr) begin
			hit_start_q <= rdata.start;
			hit_len_q   <= rdata.len;
		end
		if (cmd.init_j) begin
			j_q <= count_q;
		end else if (cmd.sh_wr) begin
			j_q <= jm1;
		end
		if (cmd.set_res) begin
			res_code_q <= cmd.res_code;
			if (cmd.hit_wr && act_q == ACT_ALLOC) begin
				res_addr_q <= start_p[15:0];
			end else if (cmd.append) begin
				res_addr_q <= top_p[15:0];
			end else begin
				res_addr_q <= 16'd0;
			end
		end
		if (cmd.out_load) begin
			out_q.result_address <= res_addr_q;
			out_q.status         <= res_code_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			count_q     <= '0;
			top_q       <= '0;
			limit_q     <= 17'(ADDR_SPACE);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (cmd.clr_idx) begin
				idx_q <= '0;
			end else if (cmd.step) begin
				idx_q <= idx_p1;
			end
			if (cmd.split_wr || cmd.append) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.append) begin
				top_q <= end_t[16:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BLOCKS))
		else $error("block count beyond table depth");
	a_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result word overwritten while waiting");
	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("append did not grow table");
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= 17'(LIMIT_CAP))
		else $error("heap top beyond limit");
endmodule
`default_nettype wire

[hdl/ffba_ctrl.sv]
// Controller: sequences the scan, the shift for a split and the result hand-off.
`default_nettype none
module ffba_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire ffba_pkg::sts_t sts,
	output ffba_pkg::cmd_t      cmd
);
	import ffba_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_CK   = 3'd3;
	localparam logic [2:0] S_SHR  = 3'd4;
	localparam logic [2:0] S_SHW  = 3'd5;
	localparam logic [2:0] S_SPW  = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.zero) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_NULL;
					state_d      = S_FIN;
				end else begin
					cmd.clr_idx = 1'b1;
					state_d     = S_RD;
				end
			end
			S_RD: begin
				if (sts.scan_end) begin
					cmd.set_res = 1'b1;
					if (sts.is_free_op) begin
						cmd.res_code = ST_INVALID;
					end else if (sts.append_ok) begin
						cmd.append   = 1'b1;
						cmd.res_code = ST_OK;
					end else begin
						cmd.res_code = ST_NOSPACE;
					end
					state_d = S_FIN;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_CK;
				end
			end
			S_CK: begin
				if (sts.hit) begin
					cmd.hit_wr   = 1'b1;
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_OK;
					if (!sts.is_free_op && sts.split_ok) begin
						cmd.init_j = 1'b1;
						state_d    = sts.no_shift ? S_SPW : S_SHR;
					end else begin
						state_d = S_FIN;
					end
				end else begin
					cmd.step = 1'b1;
					state_d  = S_RD;
				end
			end
			S_SHR: begin
				cmd.sh_rd = 1'b1;
				state_d   = S_SHW;
			end
			S_SHW: begin
				// move one entry up; stop once the slot after the hit is open
				cmd.sh_wr = 1'b1;
				state_d   = sts.sh_last ? S_SPW : S_SHR;
			end
			S_SPW: begin
				cmd.split_wr = 1'b1;
				state_d      = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

[hdl/first_fit_block_allocator.sv]
// Top level of the first-fit block allocator.
//  channel   direction  handshake           word
//  in        in         in_valid/in_stall   in_word   (action, request_size, payload_address)
//  out       out        out_valid/out_stall out_word  (result_address, status)
//  cfg       in         cfg_we              cfg_data  (heap_limit)
// The block table has one read port. A word is taken and checked, the table is scanned
// entry by entry (a read, then a check), on a split the entries after the hit are moved
// up one at a time (a read, then a write), a miss or a split is closed and the result is
// handed over. Reset is asynchronous; no clearing pass is needed. A new word is taken
// once the previous result is in the output register, even while that result is stalled.
`default_nettype none
module first_fit_block_allocator (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire ffba_pkg::in_t   in_word,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output ffba_pkg::out_t       out_word,
	input  wire logic            cfg_we,
	input  wire logic [16:0]     cfg_data
);
	import ffba_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ffba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffba_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_word   (in_word),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);
endmodule
`default_nettype wire
